// ===== rtl/core/tbp_pkg.sv =====
// ----------------------------------------------------------------------------
// tbp_pkg
// Shared constants, codes and helpers of the tournament branch predictor.
// ----------------------------------------------------------------------------
package tbp_pkg;

    localparam int GLOBAL_MAX_DEF  = 13;
    localparam int LOCAL_MAX_DEF   = 11;
    localparam int ADDRESS_MAX_DEF = 11;

    localparam int CFG_W   = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE         = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_BITS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ADDRESS_BITS = 2'd3;

    localparam logic [1:0] MODE_STATIC     = 2'd0;
    localparam logic [1:0] MODE_GSHARE     = 2'd1;
    localparam logic [1:0] MODE_TOURNAMENT = 2'd2;

    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_TRAIN   = 1'b1;

    localparam logic [1:0] CTR_WEAK_NT = 2'd1;
    localparam logic [1:0] CTR_MAX     = 2'd3;
    localparam logic [1:0] CTR_MIN     = 2'd0;

    typedef struct packed {
        logic        operation;
        logic [31:0] branch_address;
        logic        taken;
    } item_t;

    function automatic logic [1:0] bump(input logic [1:0] c, input logic up);
        logic [1:0] r;
        if (up)
        begin
            r = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
        end
        else
        begin
            r = (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/tournament_branch_predictor_top.sv =====
// ----------------------------------------------------------------------------
// tournament_branch_predictor_top
// Static, gshare or tournament branch predictor with predict and train items.
//
//   channel  | direction | handshake           | payload
//   in       | input     | in_valid/in_stall   | operation, branch_address, taken
//   out      | output    | out_valid/out_stall | predict_taken
//   cfg      | input     | cfg_we              | cfg_index, cfg_data
//
// Each item passes the table sequencer states IDLE, RD1, RD2 and DONE: read history
// and counters, read the local counter through the local history, then update or predict.
// After reset a clear pass over 2^max(GLOBAL_MAX, LOCAL_MAX, ADDRESS_MAX)
// addresses (8192 by default) runs; in_stall is high meanwhile.
// A stalled result holds the sequencer; the two-entry queue keeps taking items until it is full.
// ----------------------------------------------------------------------------
module tournament_branch_predictor_top #(
    parameter int GLOBAL_MAX  = tbp_pkg::GLOBAL_MAX_DEF,
    parameter int LOCAL_MAX   = tbp_pkg::LOCAL_MAX_DEF,
    parameter int ADDRESS_MAX = tbp_pkg::ADDRESS_MAX_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          operation,
    input  logic [31:0]                   branch_address,
    input  logic                          taken,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          predict_taken,
    input  logic                          cfg_we,
    input  logic [tbp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tbp_pkg::CFG_W-1:0]     cfg_data
);
    import tbp_pkg::*;

    item_t                  in_item;
    item_t                  q_item;
    logic                   q_valid;
    logic                   q_pop;
    logic                   busy;
    logic [1:0]             mode;
    logic [GLOBAL_MAX-1:0]  gmask;
    logic [LOCAL_MAX-1:0]   lmask;
    logic [ADDRESS_MAX-1:0] amask;

    assign in_item.operation      = operation;
    assign in_item.branch_address = branch_address;
    assign in_item.taken          = taken;

    tbp_front #(
        .GLOBAL_MAX(GLOBAL_MAX), .LOCAL_MAX(LOCAL_MAX), .ADDRESS_MAX(ADDRESS_MAX)
    ) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_item(in_item), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .busy(busy), .q_valid(q_valid), .q_item(q_item),
        .q_pop(q_pop), .mode(mode), .gmask(gmask), .lmask(lmask), .amask(amask));

    tbp_back #(
        .GLOBAL_MAX(GLOBAL_MAX), .LOCAL_MAX(LOCAL_MAX), .ADDRESS_MAX(ADDRESS_MAX)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item),
        .q_pop(q_pop), .busy(busy), .mode(mode), .gmask(gmask), .lmask(lmask),
        .amask(amask), .out_valid(out_valid), .out_stall(out_stall),
        .predict_taken(predict_taken));
endmodule

// ===== rtl/core/tbp_ram.sv =====
// ----------------------------------------------------------------------------
// tbp_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/core/tbp_front.sv =====
// ----------------------------------------------------------------------------
// tbp_front
// Configuration registers, width masks and a two-entry item queue.
// ----------------------------------------------------------------------------
module tbp_front #(
    parameter int GLOBAL_MAX  = tbp_pkg::GLOBAL_MAX_DEF,
    parameter int LOCAL_MAX   = tbp_pkg::LOCAL_MAX_DEF,
    parameter int ADDRESS_MAX = tbp_pkg::ADDRESS_MAX_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  tbp_pkg::item_t                 in_item,
    input  logic                           cfg_we,
    input  logic [tbp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tbp_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           busy,
    output logic                           q_valid,
    output tbp_pkg::item_t                 q_item,
    input  logic                           q_pop,
    output logic [1:0]                     mode,
    output logic [GLOBAL_MAX-1:0]          gmask,
    output logic [LOCAL_MAX-1:0]           lmask,
    output logic [ADDRESS_MAX-1:0]         amask
);
    import tbp_pkg::*;

    logic [1:0]       mode_reg;
    logic [CFG_W-1:0] gbits_reg;
    logic [CFG_W-1:0] lbits_reg;
    logic [CFG_W-1:0] abits_reg;

    item_t      q_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;
    logic       push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_GSHARE;
            gbits_reg <= CFG_W'(13);
            lbits_reg <= CFG_W'(11);
            abits_reg <= CFG_W'(11);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:         mode_reg  <= cfg_data[1:0];
                REG_GLOBAL_BITS:  gbits_reg <= cfg_data;
                REG_LOCAL_BITS:   lbits_reg <= cfg_data;
                REG_ADDRESS_BITS: abits_reg <= cfg_data;
                default:          mode_reg  <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < GLOBAL_MAX; i++)
        begin
            gmask[i] = (i < int'(gbits_reg));
        end
        for (int i = 0; i < LOCAL_MAX; i++)
        begin
            lmask[i] = (i < int'(lbits_reg));
        end
        for (int i = 0; i < ADDRESS_MAX; i++)
        begin
            amask[i] = (i < int'(abits_reg));
        end
    end

    assign mode     = mode_reg;
    assign in_stall = cnt_reg[1] | busy;
    assign push     = in_valid & ~in_stall;
    assign q_valid  = cnt_reg != 2'd0;
    assign q_item   = q_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (q_pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end
endmodule

// ===== rtl/core/tbp_back.sv =====
// ----------------------------------------------------------------------------
// tbp_back
// Table sequencer: clear pass, lookups, prediction and training updates.
// ----------------------------------------------------------------------------
module tbp_back #(
    parameter int GLOBAL_MAX  = tbp_pkg::GLOBAL_MAX_DEF,
    parameter int LOCAL_MAX   = tbp_pkg::LOCAL_MAX_DEF,
    parameter int ADDRESS_MAX = tbp_pkg::ADDRESS_MAX_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  tbp_pkg::item_t         q_item,
    output logic                   q_pop,
    output logic                   busy,
    input  logic [1:0]             mode,
    input  logic [GLOBAL_MAX-1:0]  gmask,
    input  logic [LOCAL_MAX-1:0]   lmask,
    input  logic [ADDRESS_MAX-1:0] amask,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   predict_taken
);
    import tbp_pkg::*;

    localparam int GW = GLOBAL_MAX;
    localparam int LW = LOCAL_MAX;
    localparam int AW = ADDRESS_MAX;
    localparam int CW = (GW > LW) ? ((GW > AW) ? GW : AW) : ((LW > AW) ? LW : AW);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RD1   = 3'd2;
    localparam logic [2:0] ST_RD2   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] clr_reg, clr_next;
    logic [GW-1:0] gh_reg, gh_next;
    logic [GW-1:0] hist_reg, hist_next;
    logic [GW-1:0] gidx_reg, gidx_next;
    logic [AW-1:0] aidx_reg, aidx_next;
    logic [LW-1:0] lhist_reg, lhist_next;
    logic          op_reg, op_next;
    logic          tk_reg, tk_next;
    logic          out_valid_reg, out_valid_next;
    logic          pt_reg, pt_next;

    logic          gc_we, ch_we, lh_we, lc_we;
    logic [GW-1:0] gc_waddr, ch_waddr;
    logic [AW-1:0] lh_waddr;
    logic [LW-1:0] lc_waddr, lc_raddr;
    logic [1:0]    gc_wdata, ch_wdata, lc_wdata;
    logic [LW-1:0] lh_wdata;
    logic [1:0]    gc_rdata, ch_rdata, lc_rdata;
    logic [LW-1:0] lh_rdata;
    logic [GW:0]   gh_shift;
    logic [LW:0]   lh_shift;
    logic          gp, lp, ug, pred, gok, lok;

    tbp_ram #(.WIDTH(2), .DEPTH(1 << GW)) u_gc (
        .clk(clk), .we(gc_we), .waddr(gc_waddr), .wdata(gc_wdata),
        .raddr(gidx_reg), .rdata(gc_rdata));
    tbp_ram #(.WIDTH(2), .DEPTH(1 << GW)) u_ch (
        .clk(clk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
        .raddr(hist_reg), .rdata(ch_rdata));
    tbp_ram #(.WIDTH(LW), .DEPTH(1 << AW)) u_lh (
        .clk(clk), .we(lh_we), .waddr(lh_waddr), .wdata(lh_wdata),
        .raddr(aidx_reg), .rdata(lh_rdata));
    tbp_ram #(.WIDTH(2), .DEPTH(1 << LW)) u_lc (
        .clk(clk), .we(lc_we), .waddr(lc_waddr), .wdata(lc_wdata),
        .raddr(lc_raddr), .rdata(lc_rdata));

    assign lc_raddr  = (state_reg == ST_RD2) ? (lh_rdata & lmask) : lhist_reg;
    assign busy      = state_reg == ST_CLEAR;
    assign out_valid = out_valid_reg;
    assign predict_taken = pt_reg;
    assign gh_shift  = {gh_reg, tk_reg};
    assign lh_shift  = {lhist_reg, tk_reg};
    assign gp  = gc_rdata[1];
    assign lp  = lc_rdata[1];
    assign ug  = ch_rdata[1];
    assign gok = gp == tk_reg;
    assign lok = lp == tk_reg;

    always_comb
    begin
        case (mode)
            MODE_STATIC:     pred = 1'b1;
            MODE_GSHARE:     pred = gp;
            MODE_TOURNAMENT: pred = ug ? gp : lp;
            default:         pred = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        gh_next        = gh_reg;
        hist_next      = hist_reg;
        gidx_next      = gidx_reg;
        aidx_next      = aidx_reg;
        lhist_next     = lhist_reg;
        op_next        = op_reg;
        tk_next        = tk_reg;
        pt_next        = pt_reg;
        out_valid_next = out_valid_reg & out_stall;
        q_pop          = 1'b0;
        gc_we    = 1'b0;
        ch_we    = 1'b0;
        lh_we    = 1'b0;
        lc_we    = 1'b0;
        gc_waddr = gidx_reg;
        ch_waddr = hist_reg;
        lh_waddr = aidx_reg;
        lc_waddr = lhist_reg;
        gc_wdata = bump(gc_rdata, tk_reg);
        ch_wdata = (gok != lok) ? bump(ch_rdata, gok) : ch_rdata;
        lh_wdata = lh_shift[LW-1:0] & lmask;
        lc_wdata = bump(lc_rdata, tk_reg);
        case (state_reg)
            ST_CLEAR:
            begin
                gc_we    = 1'b1;
                ch_we    = 1'b1;
                lh_we    = 1'b1;
                lc_we    = 1'b1;
                gc_waddr = clr_reg[GW-1:0];
                ch_waddr = clr_reg[GW-1:0];
                lh_waddr = clr_reg[AW-1:0];
                lc_waddr = clr_reg[LW-1:0];
                gc_wdata = CTR_WEAK_NT;
                ch_wdata = CTR_WEAK_NT;
                lh_wdata = '0;
                lc_wdata = CTR_MIN;
                clr_next = clr_reg + CW'(1);
                if (&clr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    op_next    = q_item.operation;
                    tk_next    = q_item.taken;
                    hist_next  = gh_reg & gmask;
                    gidx_next  = (gh_reg ^ q_item.branch_address[GW-1:0]) & gmask;
                    aidx_next  = q_item.branch_address[AW-1:0] & amask;
                    state_next = ST_RD1;
                end
            end
            ST_RD1:
            begin
                state_next = ST_RD2;
            end
            ST_RD2:
            begin
                lhist_next = lh_rdata & lmask;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (op_reg == OP_PREDICT)
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_next = 1'b1;
                        pt_next        = pred;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    if (mode == MODE_TOURNAMENT)
                    begin
                        ch_we = 1'b1;
                        lc_we = 1'b1;
                        lh_we = 1'b1;
                    end
                    if (mode == MODE_TOURNAMENT || mode == MODE_GSHARE)
                    begin
                        gc_we   = 1'b1;
                        gh_next = gh_shift[GW-1:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            gh_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            gh_reg        <= gh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hist_reg  <= hist_next;
        gidx_reg  <= gidx_next;
        aidx_reg  <= aidx_next;
        lhist_reg <= lhist_next;
        op_reg    <= op_next;
        tk_reg    <= tk_next;
        pt_reg    <= pt_next;
    end
endmodule
